// File: hw/rtl/sip_pkg.sv
// Shared types, constants and functions of the SipHash-2-4 engine.
// No dependencies; used by the interfaces, the lane datapath and the top level.
`timescale 1ns / 1ps

package sip_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned BytesW  = 4;
  localparam int unsigned LenW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned PcW     = 3;

  localparam logic [WordW-1:0] SipC0 = 64'h736f6d6570736575;
  localparam logic [WordW-1:0] SipC1 = 64'h646f72616e646f6d;
  localparam logic [WordW-1:0] SipC2 = 64'h6c7967656e657261;
  localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;
  localparam logic [WordW-1:0] FinalXor  = 64'h0000_0000_0000_00ff;
  localparam int unsigned      LenShift  = 56;
  localparam logic [BytesW-1:0] FullBytes = 4'd8;
  localparam logic [LenW-1:0]   FullLen   = 8'd8;

  // Program entry points
  localparam logic [PcW-1:0] PcAbsorbWord = 3'd0;
  localparam logic [PcW-1:0] PcAbsorbFin  = 3'd2;

  typedef logic [3:0][WordW-1:0] lanes_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MSEL_WORD = 1'b0,
    MSEL_FIN  = 1'b1
  } msel_e;

  typedef enum logic [1:0] {
    SEQ_NEXT            = 2'd0,
    SEQ_END             = 2'd1,
    SEQ_END_IF_NOT_LAST = 2'd2
  } seq_e;

  // One control word of the sequencer program
  typedef struct packed {
    msel_e msel;     // which block feeds the xor points
    logic  pre_x;    // v3 ^= m before the round
    logic  post_x;   // v0 ^= m after the round
    logic  post_ff;  // v2 ^= 0xff after the round
    logic  emit;     // present the hash after this round
    seq_e  seq;
  } ucode_t;

  // Controls from the sequencer to the lane datapath
  typedef struct packed {
    logic load;      // load lanes from key
    logic step;      // run one round with the xor points
    logic pre_x;
    logic post_x;
    logic post_ff;
  } dp_ctl_t;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t uw;
    uw = '{msel: MSEL_WORD, pre_x: 1'b0, post_x: 1'b0, post_ff: 1'b0,
           emit: 1'b0, seq: SEQ_NEXT};
    unique case (pc)
      3'd0: begin uw.pre_x = 1'b1; end
      3'd1: begin uw.post_x = 1'b1; uw.seq = SEQ_END_IF_NOT_LAST; end
      3'd2: begin uw.msel = MSEL_FIN; uw.pre_x = 1'b1; end
      3'd3: begin
        uw.msel = MSEL_FIN; uw.post_x = 1'b1; uw.post_ff = 1'b1;
      end
      3'd4: begin uw.seq = SEQ_NEXT; end
      3'd5: begin uw.seq = SEQ_NEXT; end
      3'd6: begin uw.seq = SEQ_NEXT; end
      3'd7: begin uw.emit = 1'b1; uw.seq = SEQ_END; end
      default: begin uw.seq = SEQ_END; end
    endcase
    return uw;
  endfunction

  function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] x, int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic lanes_t sip_round(lanes_t v);
    logic [WordW-1:0] a, b, c, d;
    a = v[0]; b = v[1]; c = v[2]; d = v[3];
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    return {d, c, b, a};
  endfunction

  // Keep the low n bytes of a word
  function automatic logic [WordW-1:0] byte_mask(logic [2:0] n);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/sip_if.sv
// Valid/ready channel interfaces for message items and hash results.
// Depends on sip_pkg for field widths.
`timescale 1ns / 1ps

interface sip_msg_if;
  import sip_pkg::*;
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  msg_word;
  logic [BytesW-1:0] word_bytes;
  logic              last_word;

  modport source (output valid, output msg_word, output word_bytes,
                  output last_word, input ready);
  modport sink   (input valid, input msg_word, input word_bytes,
                  input last_word, output ready);
endinterface

interface sip_hash_if;
  import sip_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// File: hw/rtl/sip_lanes.sv
// Lane registers v0..v3 with one SipRound per step and the xor injection points.
// Depends on sip_pkg for the round function, constants and control struct.
`timescale 1ns / 1ps

module sip_lanes (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sip_pkg::dp_ctl_t         ctl_i,
  input  logic [sip_pkg::WordW-1:0] key_lo_i,
  input  logic [sip_pkg::WordW-1:0] key_hi_i,
  input  logic [sip_pkg::WordW-1:0] m_i,
  output logic [sip_pkg::WordW-1:0] hash_o
);
  import sip_pkg::*;

  lanes_t lanes_q, lanes_d;
  lanes_t pre_v, rnd_v;

  always_comb begin
    pre_v = lanes_q;
    if (ctl_i.pre_x) begin
      pre_v[3] = pre_v[3] ^ m_i;
    end
    rnd_v = sip_round(pre_v);
    if (ctl_i.post_x) begin
      rnd_v[0] = rnd_v[0] ^ m_i;
    end
    if (ctl_i.post_ff) begin
      rnd_v[2] = rnd_v[2] ^ FinalXor;
    end
  end

  always_comb begin
    priority if (ctl_i.load) begin
      lanes_d = {SipC3 ^ key_hi_i, SipC2 ^ key_lo_i, SipC1 ^ key_hi_i, SipC0 ^ key_lo_i};
    end else if (ctl_i.step) begin
      lanes_d = rnd_v;
    end else begin
      lanes_d = lanes_q;
    end
  end

  // Hash of the lanes as they leave this round
  assign hash_o = rnd_v[0] ^ rnd_v[1] ^ rnd_v[2] ^ rnd_v[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
    end else begin
      lanes_q <= lanes_d;
    end
  end

endmodule

// File: hw/rtl/siphash_2_4_keyed_hash.sv
// Top level of the keyed SipHash-2-4 engine: key registers, input capture,
// microcode sequencer and result register. Depends on sip_pkg, sip_if, sip_lanes.
`timescale 1ns / 1ps

// Usage
//   msg_in carries one little-endian 64-bit word per item; last_word marks
//   the final item, whose word_bytes (0..8, above 8 reads as 8) gives the
//   valid bytes. hash_out carries one 64-bit hash per message.
//   The key is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
//   it is sampled at the first item of each message.
// Timing
//   A small program in a control ROM runs one SipRound per cycle, except while
//   stalled, on a single round unit. A non-last item runs the compression rounds
//   of its word. A last item runs the final-block and finalization rounds (after
//   the word rounds if it has 8 bytes); the hash then enters the result register
//   that drives hash_out. msg_in.ready is high whenever no program is running,
//   so the next item is taken the cycle after the program ends.
// Reset and stall
//   Reset clears the key, lanes, length, message state and result valid.
//   The hash sits in an output register; a new message may be absorbed while
//   it waits, and the program holds on its final step only if the previous
//   hash has not yet been taken.
module siphash_2_4_keyed_hash (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sip_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sip_pkg::WordW-1:0]   cfg_data_i,
  sip_msg_if.sink                     msg_in,
  sip_hash_if.source                  hash_out
);
  import sip_pkg::*;

  logic [WordW-1:0] key_lo_q, key_hi_q;
  logic [WordW-1:0] word_q, fin_q;
  logic             last_q;
  logic [LenW-1:0]  len_q, len_d;
  logic             in_msg_q;
  logic             busy_q, busy_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] hash_q;

  logic             accept;
  logic [BytesW-1:0] nb_sat;
  logic             full;
  logic [LenW-1:0]  len_base;
  logic [WordW-1:0] fin_d;
  ucode_t           uw;
  logic             stall, run;
  dp_ctl_t          dp_ctl;
  logic [WordW-1:0] m_sel;
  logic [WordW-1:0] hash_new;

  assign accept = msg_in.valid && msg_in.ready;
  assign msg_in.ready = !busy_q;

  // Final block, built as the item is accepted
  always_comb begin
    nb_sat   = (msg_in.word_bytes > FullBytes) ? FullBytes : msg_in.word_bytes;
    full     = (nb_sat == FullBytes);
    len_base = in_msg_q ? len_q : '0;
    len_d    = len_base + (msg_in.last_word ? LenW'(nb_sat) : FullLen);
    fin_d    = full ? '0 : (msg_in.msg_word & byte_mask(nb_sat[2:0]));
    fin_d    = fin_d | (WordW'(len_d) << LenShift);
  end

  assign uw    = ucode_rom(pc_q);
  assign stall = uw.emit && out_valid_q && !hash_out.ready;
  assign run   = busy_q && !stall;
  assign m_sel = (uw.msel == MSEL_FIN) ? fin_q : word_q;

  always_comb begin
    dp_ctl.load    = accept && !in_msg_q;
    dp_ctl.step    = run;
    dp_ctl.pre_x   = uw.pre_x;
    dp_ctl.post_x  = uw.post_x;
    dp_ctl.post_ff = uw.post_ff;
  end

  // Sequencer next state
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = (msg_in.last_word && !full) ? PcAbsorbFin : PcAbsorbWord;
    end else if (run) begin
      unique case (uw.seq)
        SEQ_NEXT: pc_d = pc_q + 1'b1;
        SEQ_END: busy_d = 1'b0;
        SEQ_END_IF_NOT_LAST: begin
          if (last_q) begin
            pc_d = pc_q + 1'b1;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (hash_out.ready) begin
      out_valid_d = 1'b0;
    end
    if (run && uw.emit) begin
      out_valid_d = 1'b1;
    end
  end

  assign hash_out.valid      = out_valid_q;
  assign hash_out.hash_value = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q    <= '0;
      key_hi_q    <= '0;
      len_q       <= '0;
      in_msg_q    <= 1'b0;
      busy_q      <= 1'b0;
      pc_q        <= PcAbsorbWord;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
          CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        len_q    <= len_d;
        in_msg_q <= !msg_in.last_word;
      end
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= msg_in.msg_word;
      fin_q  <= fin_d;
      last_q <= msg_in.last_word;
    end
    if (run && uw.emit) begin
      hash_q <= hash_new;
    end
  end

  sip_lanes u_lanes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dp_ctl),
    .key_lo_i (key_lo_q),
    .key_hi_i (key_hi_q),
    .m_i      (m_sel),
    .hash_o   (hash_new)
  );

endmodule
